@@ design/rtcm3fe_pkg.sv @@
// Shared types, constants and CRC-24Q byte update for the RTCM3 frame encoder.
`default_nettype none
package rtcm3fe_pkg;

  localparam int unsigned MaxBeats = 6;
  localparam int unsigned BeatW    = 3;

  localparam logic [7:0]  SYNC_BYTE = 8'hD3;
  localparam logic [23:0] CRC_POLY  = 24'h864CFB;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } opcode_t;

  // Burst of result bytes produced by one request, oldest byte in slot 0.
  typedef struct packed {
    logic [MaxBeats-1:0][7:0] bytes;
    logic [BeatW-1:0]         count;
    logic                     has_crc;  // burst closes with the CRC bytes
    logic                     err;      // stray payload byte
  } burst_t;

  // Bitwise CRC-24Q over one byte, MSB first.
  function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ {1'b1, CRC_POLY};
      end
    end
    return c[23:0];
  endfunction

  // CRC after the sync byte alone; folded at elaboration.
  localparam logic [23:0] CRC_SYNC = crc_feed(24'h000000, SYNC_BYTE);

endpackage
`default_nettype wire

@@ design/rtcm3fe_core.sv @@
// Frame state and CRC tracking; builds the result burst for each request.
`default_nettype none
module rtcm3fe_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                opcode,
  input  wire logic [9:0]          frame_length,
  input  wire logic [7:0]          payload_byte,
  output rtcm3fe_pkg::burst_t      burst
);

  logic [23:0] crc_r, crc_nxt;
  logic [9:0]  remain_r, remain_nxt;
  logic        open_r, open_nxt;

  logic [7:0]  h1;
  logic [23:0] crc_hdr;
  logic [23:0] crc_pay;
  logic [9:0]  remain_dec;

  assign h1         = {6'b000000, frame_length[9:8]};
  assign crc_hdr    = rtcm3fe_pkg::crc_feed(rtcm3fe_pkg::crc_feed(rtcm3fe_pkg::CRC_SYNC, h1),
                                            frame_length[7:0]);
  assign crc_pay    = rtcm3fe_pkg::crc_feed(crc_r, payload_byte);
  assign remain_dec = remain_r - 10'd1;

  always_comb begin
    burst      = '0;
    crc_nxt    = crc_r;
    remain_nxt = remain_r;
    open_nxt   = open_r;
    priority if (opcode == rtcm3fe_pkg::OP_START) begin
      burst.bytes[0] = rtcm3fe_pkg::SYNC_BYTE;
      burst.bytes[1] = h1;
      burst.bytes[2] = frame_length[7:0];
      burst.bytes[3] = crc_hdr[23:16];
      burst.bytes[4] = crc_hdr[15:8];
      burst.bytes[5] = crc_hdr[7:0];
      burst.has_crc  = (frame_length == 10'd0);
      burst.count    = burst.has_crc ? 3'd6 : 3'd3;
      crc_nxt        = crc_hdr;
      remain_nxt     = frame_length;
      open_nxt       = (frame_length != 10'd0);
    end else if (!open_r) begin
      burst.err   = 1'b1;
      burst.count = 3'd1;
    end else begin
      burst.bytes[0] = payload_byte;
      burst.bytes[1] = crc_pay[23:16];
      burst.bytes[2] = crc_pay[15:8];
      burst.bytes[3] = crc_pay[7:0];
      burst.has_crc  = (remain_dec == 10'd0);
      burst.count    = burst.has_crc ? 3'd4 : 3'd1;
      crc_nxt        = crc_pay;
      remain_nxt     = remain_dec;
      open_nxt       = (remain_dec != 10'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= '0;
      remain_r <= '0;
      open_r   <= 1'b0;
    end else if (accept) begin
      crc_r    <= crc_nxt;
      remain_r <= remain_nxt;
      open_r   <= open_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/rtcm3fe_serializer.sv @@
// Result register: holds one burst and sends it out a byte per beat.
`default_nettype none
module rtcm3fe_serializer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire rtcm3fe_pkg::burst_t burst,
  output logic                     can_load,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     last_of_run,
  output logic                     frame_end,
  output logic                     error
);

  logic [rtcm3fe_pkg::MaxBeats-1:0][7:0] bytes_r, bytes_nxt;
  logic [rtcm3fe_pkg::BeatW-1:0]         count_r;
  logic                                  has_crc_r;
  logic                                  err_r;
  logic                                  take;

  assign out_valid   = (count_r != '0);
  assign take        = out_valid && out_ready;
  assign last_of_run = (count_r == 3'd1);
  assign can_load    = !out_valid || (take && last_of_run);
  assign out_byte    = bytes_r[0];
  assign frame_end   = has_crc_r && last_of_run;
  assign error       = err_r;

  always_comb begin
    for (int i = 0; i < rtcm3fe_pkg::MaxBeats - 1; i++) begin
      bytes_nxt[i] = bytes_r[i+1];
    end
    bytes_nxt[rtcm3fe_pkg::MaxBeats-1] = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (load) begin
      count_r <= burst.count;
    end else if (take) begin
      count_r <= count_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r   <= burst.bytes;
      has_crc_r <= burst.has_crc;
      err_r     <= burst.err;
    end else if (take) begin
      bytes_r   <= bytes_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/rtcm3_frame_encoder_top.sv @@
// Top level of the RTCM3 frame encoder with CRC-24Q.
// Latency: first result byte is valid the cycle after its request is accepted.
// Throughput: one result byte per cycle when not stalled; a request yields 1, 3, 4 or
// 6 bytes; the next request is taken in the same cycle its predecessor's last byte leaves.
// Single-byte requests (open-frame payload, stray bytes) stream at one per unstalled cycle.
// Reset clears the frame state (CRC, remaining count, open flag) and drops pending bytes.
`default_nettype none
module rtcm3_frame_encoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [9:0] frame_length, [17:10] payload_byte, rest zero
  input  wire logic        in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // last_of_run
  output logic [1:0]       out_tuser   // [0] frame_end, [1] error
);

  rtcm3fe_pkg::burst_t burst;
  logic                accept;
  logic                can_load;
  logic                frame_end;
  logic                error;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;
  assign out_tuser = {error, frame_end};

  rtcm3fe_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .opcode       (in_tuser),
    .frame_length (in_tdata[9:0]),
    .payload_byte (in_tdata[17:10]),
    .burst        (burst)
  );

  rtcm3fe_serializer u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .burst       (burst),
    .can_load    (can_load),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .last_of_run (out_tlast),
    .frame_end   (frame_end),
    .error       (error)
  );

endmodule
`default_nettype wire

@@ design/rtcm3fe_checker.sv @@
// Port-level checks for the RTCM3 frame encoder, bound to the top level.
`default_nettype none
module rtcm3fe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast,
  input wire logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tdata == 8'h00 && !out_tuser[0])
    else $error("error result malformed");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame end not on last result");

  a_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request taken mid burst");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind rtcm3_frame_encoder_top rtcm3fe_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ sim/rtcm3_frame_encoder_top_tb.sv @@
// Self-checking testbench for the RTCM3 frame encoder: framing, CRC-24Q and stray-byte errors.
`timescale 1ns / 1ps
module rtcm3_frame_encoder_top_tb;

  localparam int unsigned RandRequests = 220;
  localparam int unsigned PhaseLen     = 90;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fend;
    logic       err;
  } frame_byte_t;

  // One stimulus row; the first n_typed results may be given by hand.
  typedef struct packed {
    rtcm3fe_pkg::opcode_t op;
    logic [9:0]           len;
    logic [7:0]           data;
    logic [1:0]           n_typed;
    frame_byte_t [0:2]    typed;
  } stim_row_t;

  localparam frame_byte_t NO_BYTE = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  rtcm3_frame_encoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [23:0]  crc_acc;
  logic [9:0]   bytes_left;
  logic         in_frame;
  frame_byte_t  pending_bytes[$];

  int unsigned  mismatches = 0;
  int unsigned  requests_sent = 0;
  int unsigned  send_idle_pct = 7;
  int unsigned  recv_stall_pct = 77;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [23:0] crc24q_step(logic [23:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[23] ^ b[i];
      acc = {acc[22:0], 1'b0};
      if (fb) begin
        acc = acc ^ rtcm3fe_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic frame_byte_t fb_of(logic [7:0] d, logic l, logic f, logic e);
    frame_byte_t r;
    r.data = d;
    r.last = l;
    r.fend = f;
    r.err  = e;
    return r;
  endfunction

  function automatic stim_row_t mk_row(rtcm3fe_pkg::opcode_t op, logic [9:0] len,
                                       logic [7:0] data, logic [1:0] n, frame_byte_t t0,
                                       frame_byte_t t1, frame_byte_t t2);
    stim_row_t r;
    r.op       = op;
    r.len      = len;
    r.data     = data;
    r.n_typed  = n;
    r.typed[0] = t0;
    r.typed[1] = t1;
    r.typed[2] = t2;
    return r;
  endfunction

  task automatic push_crc_tail();
    pending_bytes.push_back(fb_of(crc_acc[23:16], 1'b0, 1'b0, 1'b0));
    pending_bytes.push_back(fb_of(crc_acc[15:8], 1'b0, 1'b0, 1'b0));
    pending_bytes.push_back(fb_of(crc_acc[7:0], 1'b1, 1'b1, 1'b0));
    in_frame   = 1'b0;
    bytes_left = '0;
  endtask

  // Expected output bytes for one accepted request.
  task automatic frame_predict(rtcm3fe_pkg::opcode_t op, logic [9:0] len, logic [7:0] data);
    logic [7:0] hi_len;
    hi_len = {6'b0, len[9:8]};
    if (op == rtcm3fe_pkg::OP_START) begin
      crc_acc = crc24q_step(24'h0, rtcm3fe_pkg::SYNC_BYTE);
      crc_acc = crc24q_step(crc_acc, hi_len);
      crc_acc = crc24q_step(crc_acc, len[7:0]);
      pending_bytes.push_back(fb_of(rtcm3fe_pkg::SYNC_BYTE, 1'b0, 1'b0, 1'b0));
      pending_bytes.push_back(fb_of(hi_len, 1'b0, 1'b0, 1'b0));
      pending_bytes.push_back(fb_of(len[7:0], len != 10'd0, 1'b0, 1'b0));
      bytes_left = len;
      in_frame   = 1'b1;
      if (len == 10'd0) begin
        push_crc_tail();
      end
    end else if (!in_frame) begin
      pending_bytes.push_back(fb_of(8'h00, 1'b1, 1'b0, 1'b1));
    end else begin
      crc_acc    = crc24q_step(crc_acc, data);
      bytes_left = bytes_left - 10'd1;
      pending_bytes.push_back(fb_of(data, bytes_left != 10'd0, 1'b0, 1'b0));
      if (bytes_left == 10'd0) begin
        push_crc_tail();
      end
    end
  endtask

  task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t: mismatch on %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch("unexpected output byte", out_tdata, 8'h00);
      end else begin
        want = pending_bytes.pop_front();
        if (out_tdata !== want.data) note_mismatch("out_byte", out_tdata, want.data);
        if (out_tlast !== want.last) begin
          note_mismatch("last_of_run", 8'(out_tlast), 8'(want.last));
        end
        if (out_tuser[0] !== want.fend) begin
          note_mismatch("frame_end", 8'(out_tuser[0]), 8'(want.fend));
        end
        if (out_tuser[1] !== want.err) begin
          note_mismatch("error", 8'(out_tuser[1]), 8'(want.err));
        end
      end
    end
  end

  // Drives one request, waits for the handshake, then updates the predictor.
  task automatic send_request(stim_row_t r);
    int unsigned base;
    if (requests_sent < PhaseLen) begin
      send_idle_pct  = 7;
      recv_stall_pct = 77;
    end else if (requests_sent < 2 * PhaseLen) begin
      send_idle_pct  = 77;
      recv_stall_pct = 7;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= {6'b0, r.data, r.len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    base = pending_bytes.size();
    frame_predict(r.op, r.len, r.data);
    for (int k = 0; k < r.n_typed; k++) begin
      pending_bytes[base + k] = r.typed[k];
    end
    requests_sent++;
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned n_payload;
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_request(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'($urandom), 8'($urandom), 2'd0,
                          NO_BYTE, NO_BYTE, NO_BYTE));
    end else begin
      len = ($urandom_range(99) < 75) ? $urandom_range(6) : $urandom_range(30, 7);
      n_payload = len;
      // broken frame: cut short, the next start abandons it
      if (kind < 22 && len > 0) begin
        n_payload = $urandom_range(len - 1);
      end
      send_request(mk_row(rtcm3fe_pkg::OP_START, 10'(len), 8'($urandom), 2'd0,
                          NO_BYTE, NO_BYTE, NO_BYTE));
      for (int i = 0; i < n_payload; i++) begin
        send_request(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'($urandom), 8'($urandom), 2'd0,
                            NO_BYTE, NO_BYTE, NO_BYTE));
      end
    end
  endtask

  initial begin
    stim_row_t   directed_rows[$];
    frame_byte_t stray;
    frame_byte_t sync_b;
    stray  = fb_of(8'h00, 1'b1, 1'b0, 1'b1);
    sync_b = fb_of(rtcm3fe_pkg::SYNC_BYTE, 1'b0, 1'b0, 1'b0);
    crc_acc    = '0;
    bytes_left = '0;
    in_frame   = 1'b0;

    // stray byte straight after reset
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h3FF, 8'hA5, 2'd1,
                                   stray, NO_BYTE, NO_BYTE));
    // zero length: header plus CRC at once
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'd0, 8'hFF, 2'd3,
                                   sync_b, fb_of(8'h00, 1'b0, 1'b0, 1'b0),
                                   fb_of(8'h00, 1'b0, 1'b0, 1'b0)));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'd0, 8'h00, 2'd1,
                                   stray, NO_BYTE, NO_BYTE));
    // longest frame, abandoned after two bytes
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'd1023, 8'h00, 2'd3,
                                   sync_b, fb_of(8'h03, 1'b0, 1'b0, 1'b0),
                                   fb_of(8'hFF, 1'b1, 1'b0, 1'b0)));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h000, 8'hFF, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h3FF, 8'h00, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'd1, 8'h00, 2'd3,
                                   sync_b, fb_of(8'h00, 1'b0, 1'b0, 1'b0),
                                   fb_of(8'h01, 1'b1, 1'b0, 1'b0)));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h155, 8'h5A, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'd2, 8'hAA, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h2AA, 8'h01, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h000, 8'h80, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'h2AA, 8'h55, 2'd3,
                                   sync_b, fb_of(8'h02, 1'b0, 1'b0, 1'b0),
                                   fb_of(8'hAA, 1'b1, 1'b0, 1'b0)));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h000, 8'h55, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'h155, 8'h00, 2'd3,
                                   sync_b, fb_of(8'h01, 1'b0, 1'b0, 1'b0),
                                   fb_of(8'h55, 1'b1, 1'b0, 1'b0)));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'd3, 8'h00, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h3FF, 8'h00, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h000, 8'hFF, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h000, 8'hC3, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h3FF, 8'hFF, 2'd1,
                                   stray, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'd0, 8'h00, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'h200, 8'hFF, 2'd3,
                                   sync_b, fb_of(8'h02, 1'b0, 1'b0, 1'b0),
                                   fb_of(8'h00, 1'b1, 1'b0, 1'b0)));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_START, 10'd1, 8'h00, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));
    directed_rows.push_back(mk_row(rtcm3fe_pkg::OP_PAYLOAD, 10'h000, 8'h7E, 2'd0,
                                   NO_BYTE, NO_BYTE, NO_BYTE));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i]);
    end
    while (requests_sent < directed_rows.size() + RandRequests) begin
      send_random_frame();
    end
    in_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("rtcm3_frame_encoder_top test passed");
    end else begin
      $display("rtcm3_frame_encoder_top test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rtcm3_frame_encoder_top test failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/rtcm3fe_pkg.sv
design/rtcm3fe_core.sv
design/rtcm3fe_serializer.sv
design/rtcm3_frame_encoder_top.sv
design/rtcm3fe_checker.sv
sim/rtcm3_frame_encoder_top_tb.sv
